// ===== src/cc20_pkg.sv =====
package cc20_pkg;

  // Cipher geometry.
  localparam int DoubleRounds = 10;
  localparam int BlockBytes   = 64;
  localparam int RoundW       = $clog2(DoubleRounds);
  localparam int OffW         = $clog2(BlockBytes);

  // Depth of the queue between the front and the back.
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);

  // Fixed words that open the cipher state.
  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CfgKey01   = 3'd0,
    CfgKey23   = 3'd1,
    CfgKey45   = 3'd2,
    CfgKey67   = 3'd3,
    CfgNonce01 = 3'd4,
    CfgNonce2  = 3'd5,
    CfgCounter = 3'd6
  } cfg_idx_e;

  // One input item as it travels through the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } cc20_item_t;

  // Request for one keystream block.
  typedef struct packed {
    logic [7:0][31:0] key;
    logic [2:0][31:0] nonce;
    logic [31:0]      counter;
  } cc20_blk_req_t;

  // Rotation of one quarter-round sub-step: 16, 12, 8, then 7 bits left.
  function automatic logic [31:0] qr_rot(logic [31:0] v, logic [1:0] sub);
    logic [31:0] r;
    case (sub)
      2'd0:    r = {v[15:0], v[31:16]};
      2'd1:    r = {v[19:0], v[31:20]};
      2'd2:    r = {v[23:0], v[31:24]};
      default: r = {v[24:0], v[31:25]};
    endcase
    return r;
  endfunction

endpackage

// ===== src/cc20_queue.sv =====
module cc20_queue import cc20_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cc20_item_t item_i,
  output logic       full_o,
  output logic       valid_o,
  output cc20_item_t item_o,
  input  logic       pop_i
);

  cc20_item_t             mem_q [QueueDepth];
  logic [QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]         count_q, count_d;
  logic                   do_push;
  logic                   do_pop;

  // Push and pop qualifiers; a push into a full queue is dropped.
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  assign full_o  = (count_q == (QPtrW + 1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage of queued items.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== src/cc20_core.sv =====
module cc20_core import cc20_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  cc20_blk_req_t    req_i,
  output logic             done_o,
  output logic [15:0][31:0] ks_o
);

  typedef enum logic [1:0] {
    CIdle,
    CRun,
    CDone
  } core_state_e;

  core_state_e       state_q;
  logic [RoundW-1:0] round_q;
  logic [2:0]        step_q;
  logic [15:0][31:0] w_q;
  logic [15:0][31:0] init_q;
  logic [15:0][31:0] init_d;
  logic [15:0][31:0] w_step;

  logic              diag;
  logic [1:0]        sub;
  logic [1:0]        lane;
  logic [3:0]        ia, ib, ic, id;
  logic [3:0]        ix, iy, iz;
  logic [31:0]       sum;

  // Initial cipher state from the constants, key, counter and nonce.
  always_comb begin
    init_d[0]  = Sigma0;
    init_d[1]  = Sigma1;
    init_d[2]  = Sigma2;
    init_d[3]  = Sigma3;
    for (int k = 0; k < 8; k++) begin
      init_d[4 + k] = req_i.key[k];
    end
    init_d[12] = req_i.counter;
    init_d[13] = req_i.nonce[0];
    init_d[14] = req_i.nonce[1];
    init_d[15] = req_i.nonce[2];
  end

  // One sub-step of four quarter-rounds side by side. The upper step bit
  // picks column or diagonal order, the lower two bits the sub-step.
  always_comb begin
    w_step = w_q;
    diag   = step_q[2];
    sub    = step_q[1:0];
    lane   = '0;
    ia     = '0;
    ib     = '0;
    ic     = '0;
    id     = '0;
    ix     = '0;
    iy     = '0;
    iz     = '0;
    sum    = '0;
    for (int j = 0; j < 4; j++) begin
      lane = 2'(j);
      ia   = {2'b00, lane};
      ib   = {2'b01, lane + {1'b0, diag}};
      ic   = {2'b10, lane + {diag, 1'b0}};
      id   = {2'b11, lane + {diag, diag}};
      if (!sub[0]) begin
        ix = ia;
        iy = ib;
        iz = id;
      end else begin
        ix = ic;
        iy = id;
        iz = ib;
      end
      sum        = w_q[ix] + w_q[iy];
      w_step[ix] = sum;
      w_step[iz] = qr_rot(w_q[iz] ^ sum, sub);
    end
  end

  // Sequencer over double rounds and sub-steps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CIdle;
      round_q <= '0;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        CIdle: begin
          if (start_i) begin
            round_q <= '0;
            step_q  <= '0;
            state_q <= CRun;
          end
        end
        CRun: begin
          step_q <= step_q + 1'b1;
          if (step_q == 3'd7) begin
            if (round_q == RoundW'(DoubleRounds - 1)) begin
              state_q <= CDone;
            end else begin
              round_q <= round_q + 1'b1;
            end
          end
        end
        CDone: begin
          state_q <= CIdle;
        end
        default: begin
          state_q <= CIdle;
        end
      endcase
    end
  end

  // Working state and saved input state.
  always_ff @(posedge clk_i) begin
    if (state_q == CIdle && start_i) begin
      w_q    <= init_d;
      init_q <= init_d;
    end else if (state_q == CRun) begin
      w_q <= w_step;
    end
  end

  // Final add of the input state gives the keystream block.
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      ks_o[k] = w_q[k] + init_q[k];
    end
  end

  assign done_o = (state_q == CDone);

endmodule

// ===== src/cc20_back.sv =====
module cc20_back import cc20_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  cc20_item_t        head_i,
  output logic              pop_o,
  input  logic [7:0][31:0]  key_i,
  input  logic [2:0][31:0]  nonce_i,
  input  logic [31:0]       init_counter_i,
  output logic              blk_start_o,
  output cc20_blk_req_t     blk_req_o,
  input  logic              blk_done_i,
  input  logic [15:0][31:0] blk_ks_i,
  output logic              out_valid_o,
  output logic [7:0]        out_byte_o,
  input  logic              out_stall_i
);

  typedef enum logic {
    BIdle,
    BGen
  } back_state_e;

  back_state_e       state_q;
  logic [31:0]       counter_q;
  logic [OffW-1:0]   offset_q;
  logic              ks_valid_q;
  logic              first_taken_q;
  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic [15:0][31:0] ks_q;

  logic              restart;
  logic [31:0]       eff_ctr;
  logic [OffW-1:0]   eff_off;
  logic              eff_valid;
  logic              out_free;
  logic              pop;
  logic              start;
  logic [OffW-1:0]   next_off;
  logic              wrap;
  logic [31:0]       ks_word;
  logic [7:0]        ks_byte;

  // A first flag not yet acted on reloads the counter and drops the block.
  assign restart   = head_valid_i & head_i.first & ~first_taken_q;
  assign eff_ctr   = restart ? init_counter_i : counter_q;
  assign eff_off   = restart ? '0 : offset_q;
  assign eff_valid = ~restart & ks_valid_q;

  // The output register frees up when it is empty or being taken.
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign pop      = (state_q == BIdle) & head_valid_i & eff_valid & out_free;
  assign start    = (state_q == BIdle) & head_valid_i & ~eff_valid;

  assign next_off = eff_off + 1'b1;
  assign wrap     = (next_off == '0);

  // Keystream byte at the current offset.
  assign ks_word = ks_q[eff_off[OffW-1:2]];
  assign ks_byte = ks_word[{eff_off[1:0], 3'b000} +: 8];

  assign blk_start_o       = start;
  assign blk_req_o.key     = key_i;
  assign blk_req_o.nonce   = nonce_i;
  assign blk_req_o.counter = eff_ctr;

  assign pop_o       = pop;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

  // Control: stream position, block status and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= BIdle;
      counter_q     <= '0;
      offset_q      <= '0;
      ks_valid_q    <= 1'b0;
      first_taken_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        BIdle: begin
          if (pop) begin
            counter_q     <= wrap ? eff_ctr + 1'b1 : eff_ctr;
            offset_q      <= next_off;
            first_taken_q <= 1'b0;
            if (wrap) begin
              ks_valid_q <= 1'b0;
            end
          end else if (start) begin
            counter_q     <= eff_ctr;
            offset_q      <= eff_off;
            first_taken_q <= first_taken_q | restart;
            state_q       <= BGen;
          end
        end
        BGen: begin
          if (blk_done_i) begin
            ks_valid_q <= 1'b1;
            state_q    <= BIdle;
          end
        end
        default: begin
          state_q <= BIdle;
        end
      endcase
    end
  end

  // Keystream block and output byte.
  always_ff @(posedge clk_i) begin
    if (state_q == BGen && blk_done_i) begin
      ks_q <= blk_ks_i;
    end
    if (pop) begin
      out_byte_q <= head_i.data ^ ks_byte;
    end
  end

  // A byte only leaves the queue against a held block.
  a_pop_needs_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> ks_valid_q)
    else $error("byte consumed without a keystream block");

  // The round core only finishes while a block is awaited.
  a_done_in_gen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_done_i |-> (state_q == BGen))
    else $error("block finished while none was requested");

  // The last byte of a block retires it.
  a_wrap_drops_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && wrap) |=> !ks_valid_q)
    else $error("block kept after its last byte");

  // A block request moves the back into generation.
  a_start_to_gen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (state_q == BGen))
    else $error("block request not followed by generation");

endmodule

// ===== src/chacha20_stream_cipher.sv =====
// ChaCha20 byte stream cipher with a 256-bit key, 32-bit block counter and
// 96-bit nonce taken from seven configuration registers.
// Input channel: data_byte_i and first_i with in_valid_i / in_stall_o. A
// transaction with first_i set reloads the block counter from the
// initial_counter register and restarts the keystream at byte 0.
// Output channel: out_byte_o with out_valid_o / out_stall_i; each input
// transaction gives exactly one output transaction, in order.
// Configuration: write cfg_wdata_i to register cfg_index_i while cfg_we_i is
// high; write only while the block is idle. Key and nonce changes apply from
// the next keystream block that is generated.
// Flow: a four-entry queue takes input transactions while the back end
// works. A keystream block is made on demand by an iterative round core
// that does one sub-step of four quarter-rounds per cycle over the ten
// double rounds; the first byte of each block leaves once its block is
// made, and the other 63 bytes follow one per cycle while the receiver
// does not stall.
// Reset clears the registers, the counter and the byte offset; the stream
// then starts at counter 0, offset 0. When the receiver stalls, the output
// byte holds, the back end waits, and the queue fills until in_stall_o rises.
module chacha20_stream_cipher import cc20_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i
);

  logic [63:0]      key01_q;
  logic [63:0]      key23_q;
  logic [63:0]      key45_q;
  logic [63:0]      key67_q;
  logic [63:0]      nonce01_q;
  logic [31:0]      nonce2_q;
  logic [31:0]      init_counter_q;

  logic [7:0][31:0] key;
  logic [2:0][31:0] nonce;

  cc20_item_t       in_item;
  cc20_item_t       head;
  logic             head_valid;
  logic             pop;
  logic             queue_full;
  logic             blk_start;
  cc20_blk_req_t    blk_req;
  logic             blk_done;
  logic [15:0][31:0] blk_ks;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key01_q        <= '0;
      key23_q        <= '0;
      key45_q        <= '0;
      key67_q        <= '0;
      nonce01_q      <= '0;
      nonce2_q       <= '0;
      init_counter_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgKey01:   key01_q        <= cfg_wdata_i;
        CfgKey23:   key23_q        <= cfg_wdata_i;
        CfgKey45:   key45_q        <= cfg_wdata_i;
        CfgKey67:   key67_q        <= cfg_wdata_i;
        CfgNonce01: nonce01_q      <= cfg_wdata_i;
        CfgNonce2:  nonce2_q       <= cfg_wdata_i[31:0];
        CfgCounter: init_counter_q <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  // Key and nonce as little-endian words.
  assign key[0]   = key01_q[31:0];
  assign key[1]   = key01_q[63:32];
  assign key[2]   = key23_q[31:0];
  assign key[3]   = key23_q[63:32];
  assign key[4]   = key45_q[31:0];
  assign key[5]   = key45_q[63:32];
  assign key[6]   = key67_q[31:0];
  assign key[7]   = key67_q[63:32];
  assign nonce[0] = nonce01_q[31:0];
  assign nonce[1] = nonce01_q[63:32];
  assign nonce[2] = nonce2_q;

  // Front: accept input transactions into the queue.
  assign in_item.data  = data_byte_i;
  assign in_item.first = first_i;
  assign in_stall_o    = queue_full;

  cc20_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .item_i  (in_item),
    .full_o  (queue_full),
    .valid_o (head_valid),
    .item_o  (head),
    .pop_i   (pop)
  );

  // Back: stream control and output register.
  cc20_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .key_i          (key),
    .nonce_i        (nonce),
    .init_counter_i (init_counter_q),
    .blk_start_o    (blk_start),
    .blk_req_o      (blk_req),
    .blk_done_i     (blk_done),
    .blk_ks_i       (blk_ks),
    .out_valid_o    (out_valid_o),
    .out_byte_o     (out_byte_o),
    .out_stall_i    (out_stall_i)
  );

  // Keystream block generator.
  cc20_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (blk_start),
    .req_i   (blk_req),
    .done_o  (blk_done),
    .ks_o    (blk_ks)
  );

endmodule
